@@ design/tkd_pkg.sv @@
// Shared types, codes and lookup functions for the terminal key escape decoder.
// No dependencies; tkd_decode and the top level refer to this package by scoped names.
package tkd_pkg;

   // Configuration register indexes and widths
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_ESC_WAIT = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEQ_WAIT = 1'd1;
   localparam logic [CSR_DATA_W-1:0]  ESC_WAIT_RESET = 16'd20;
   localparam logic [CSR_DATA_W-1:0]  SEQ_WAIT_RESET = 16'd5;

   // Decoder phase codes
   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_ESC  = 2'd1;
   localparam logic [1:0] PH_CSI  = 2'd2;
   localparam logic [1:0] PH_SS3  = 2'd3;

   // Event kinds
   localparam logic [1:0] KIND_CHAR = 2'd0;
   localparam logic [1:0] KIND_KEY  = 2'd1;
   localparam logic [1:0] KIND_CTRL = 2'd2;
   localparam logic [1:0] KIND_SS3  = 2'd3;

   // Request actions
   localparam logic ACT_BYTE = 1'b0;
   localparam logic ACT_TICK = 1'b1;

   // Key codes
   localparam logic [5:0] K_CTRL_A    = 6'd0;
   localparam logic [5:0] K_CTRL_C    = 6'd1;
   localparam logic [5:0] K_CTRL_D    = 6'd2;
   localparam logic [5:0] K_CTRL_E    = 6'd3;
   localparam logic [5:0] K_CTRL_F    = 6'd4;
   localparam logic [5:0] K_TAB       = 6'd5;
   localparam logic [5:0] K_ENTER     = 6'd6;
   localparam logic [5:0] K_CTRL_K    = 6'd7;
   localparam logic [5:0] K_CTRL_L    = 6'd8;
   localparam logic [5:0] K_CTRL_N    = 6'd9;
   localparam logic [5:0] K_CTRL_P    = 6'd10;
   localparam logic [5:0] K_CTRL_U    = 6'd11;
   localparam logic [5:0] K_CTRL_W    = 6'd12;
   localparam logic [5:0] K_CTRL_X    = 6'd13;
   localparam logic [5:0] K_CTRL_Z    = 6'd14;
   localparam logic [5:0] K_ESCAPE    = 6'd15;
   localparam logic [5:0] K_UP        = 6'd16;
   localparam logic [5:0] K_DOWN      = 6'd17;
   localparam logic [5:0] K_RIGHT     = 6'd18;
   localparam logic [5:0] K_LEFT      = 6'd19;
   localparam logic [5:0] K_HOME      = 6'd20;
   localparam logic [5:0] K_END       = 6'd21;
   localparam logic [5:0] K_INSERT    = 6'd22;
   localparam logic [5:0] K_DELETE    = 6'd23;
   localparam logic [5:0] K_PAGE_UP   = 6'd24;
   localparam logic [5:0] K_PAGE_DOWN = 6'd25;
   localparam logic [5:0] K_F5        = 6'd26;
   localparam logic [5:0] K_F6        = 6'd27;
   localparam logic [5:0] K_F7        = 6'd28;
   localparam logic [5:0] K_F8        = 6'd29;
   localparam logic [5:0] K_F9        = 6'd30;
   localparam logic [5:0] K_F10       = 6'd31;
   localparam logic [5:0] K_F11       = 6'd32;
   localparam logic [5:0] K_F12       = 6'd33;
   localparam logic [5:0] K_F1        = 6'd34;
   localparam logic [5:0] K_F2        = 6'd35;
   localparam logic [5:0] K_F3        = 6'd36;
   localparam logic [5:0] K_F4        = 6'd37;
   localparam logic [5:0] NO_KEY      = 6'd63;

   // Byte values
   localparam logic [7:0] CH_ESC      = 8'd27;
   localparam logic [7:0] CH_SPACE    = 8'd32;
   localparam logic [7:0] CH_LBRACKET = 8'h5B;
   localparam logic [7:0] CH_SS3      = 8'h4F;  // 'O', also the unknown-SS3 byte
   localparam logic [7:0] CH_ZERO     = 8'h30;
   localparam logic [7:0] CH_NINE     = 8'h39;
   localparam logic [7:0] CH_SEMI     = 8'h3B;
   localparam logic [7:0] CH_TILDE    = 8'h7E;
   localparam logic [7:0] CH_A        = 8'h41;
   localparam logic [7:0] CH_B        = 8'h42;
   localparam logic [7:0] CH_C        = 8'h43;
   localparam logic [7:0] CH_D        = 8'h44;
   localparam logic [7:0] CH_F        = 8'h46;
   localparam logic [7:0] CH_H        = 8'h48;
   localparam logic [7:0] CH_P        = 8'h50;
   localparam logic [7:0] CH_Q        = 8'h51;
   localparam logic [7:0] CH_R        = 8'h52;
   localparam logic [7:0] CH_S        = 8'h53;

   localparam logic [6:0] NUM_SAT = 7'd100;
   localparam logic [6:0] NUM_MAX = 7'd99;

   typedef struct packed {
      logic       action;
      logic [7:0] byte_in;
   } req_type;

   typedef struct packed {
      logic [1:0] event_kind;
      logic [5:0] key_code;
      logic [7:0] byte_out;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  phase;
      logic [15:0] wait_count;
      logic [6:0]  first_number;
      logic        digit_seen;
      logic        number_closed;
   } state_type;

   typedef struct packed {
      logic    emit;
      rsp_type result;
   } dec_out_type;

   // Control byte 0..31 to named key, NO_KEY for a generic control event
   function automatic logic [5:0] ctrl_key(input logic [4:0] code);
      logic [5:0] k;
      unique case (code)
         5'd1:    k = K_CTRL_A;
         5'd3:    k = K_CTRL_C;
         5'd4:    k = K_CTRL_D;
         5'd5:    k = K_CTRL_E;
         5'd6:    k = K_CTRL_F;
         5'd9:    k = K_TAB;
         5'd10:   k = K_ENTER;
         5'd11:   k = K_CTRL_K;
         5'd12:   k = K_CTRL_L;
         5'd13:   k = K_ENTER;
         5'd14:   k = K_CTRL_N;
         5'd16:   k = K_CTRL_P;
         5'd21:   k = K_CTRL_U;
         5'd23:   k = K_CTRL_W;
         5'd24:   k = K_CTRL_X;
         5'd26:   k = K_CTRL_Z;
         5'd27:   k = K_ESCAPE;
         default: k = NO_KEY;
      endcase
      return k;
   endfunction

   // First CSI number closed by '~'
   function automatic logic [5:0] tilde_key(input logic [6:0] num);
      logic [5:0] k;
      unique case (num)
         7'd1:    k = K_HOME;
         7'd2:    k = K_INSERT;
         7'd3:    k = K_DELETE;
         7'd4:    k = K_END;
         7'd5:    k = K_PAGE_UP;
         7'd6:    k = K_PAGE_DOWN;
         7'd15:   k = K_F5;
         7'd17:   k = K_F6;
         7'd18:   k = K_F7;
         7'd19:   k = K_F8;
         7'd20:   k = K_F9;
         7'd21:   k = K_F10;
         7'd23:   k = K_F11;
         7'd24:   k = K_F12;
         default: k = NO_KEY;
      endcase
      return k;
   endfunction

endpackage

@@ design/tkd_req_if.sv @@
// Request channel: valid/ready handshake carrying one byte or tick.
// No dependencies.
interface tkd_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] byte_in;

   modport source (output valid, action, byte_in, input ready);
   modport sink   (input valid, action, byte_in, output ready);
endinterface

@@ design/tkd_rsp_if.sv @@
// Response channel: valid/ready handshake carrying one key event.
// No dependencies.
interface tkd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] event_kind;
   logic [5:0] key_code;
   logic [7:0] byte_out;

   modport source (output valid, event_kind, key_code, byte_out, input ready);
   modport sink   (input valid, event_kind, key_code, byte_out, output ready);
endinterface

@@ design/tkd_decode.sv @@
// Next-state and event logic for one request of the key escape decoder.
// Depends on tkd_pkg.
module tkd_decode (
   input  tkd_pkg::state_type   state_cur,
   input  tkd_pkg::req_type     req_cur,
   input  logic [15:0]          esc_wait,
   input  logic [15:0]          seq_wait,
   output tkd_pkg::state_type   state_nxt,
   output tkd_pkg::dec_out_type dec_out
);

   logic [7:0]  b;
   logic [15:0] limit;
   logic [15:0] wait_inc;
   logic [10:0] num_acc;
   logic [5:0]  key;

   assign b        = req_cur.byte_in;
   assign limit    = (state_cur.phase == tkd_pkg::PH_ESC) ? esc_wait : seq_wait;
   assign wait_inc = state_cur.wait_count + 16'd1;
   assign num_acc  = ({4'd0, state_cur.first_number} * 11'd10) + {7'd0, b[3:0]};

   always_comb begin
      state_nxt      = state_cur;
      dec_out.emit   = 1'b0;
      dec_out.result = '0;
      key            = tkd_pkg::NO_KEY;

      if (req_cur.action == tkd_pkg::ACT_TICK) begin
         if (state_cur.phase != tkd_pkg::PH_IDLE) begin
            state_nxt.wait_count = wait_inc;
            if (!(wait_inc < limit)) begin
               dec_out.emit = 1'b1;
               if (state_cur.phase == tkd_pkg::PH_SS3) begin
                  dec_out.result.event_kind = tkd_pkg::KIND_SS3;
                  dec_out.result.byte_out   = tkd_pkg::CH_SS3;
               end else begin
                  dec_out.result.event_kind = tkd_pkg::KIND_KEY;
                  dec_out.result.key_code   = tkd_pkg::K_ESCAPE;
               end
            end
         end
      end else begin
         unique case (state_cur.phase)
            tkd_pkg::PH_IDLE: begin
               if (b == tkd_pkg::CH_ESC) begin
                  state_nxt.phase      = tkd_pkg::PH_ESC;
                  state_nxt.wait_count = '0;
               end else if (b < tkd_pkg::CH_SPACE) begin
                  key          = tkd_pkg::ctrl_key(b[4:0]);
                  dec_out.emit = 1'b1;
                  if (key == tkd_pkg::NO_KEY) begin
                     dec_out.result.event_kind = tkd_pkg::KIND_CTRL;
                     dec_out.result.byte_out   = b;
                  end else begin
                     dec_out.result.event_kind = tkd_pkg::KIND_KEY;
                     dec_out.result.key_code   = key;
                  end
               end else begin
                  dec_out.emit              = 1'b1;
                  dec_out.result.event_kind = tkd_pkg::KIND_CHAR;
                  dec_out.result.byte_out   = b;
               end
            end

            tkd_pkg::PH_ESC: begin
               state_nxt.wait_count = '0;
               if (b == tkd_pkg::CH_LBRACKET) begin
                  state_nxt.phase         = tkd_pkg::PH_CSI;
                  state_nxt.first_number  = '0;
                  state_nxt.digit_seen    = 1'b0;
                  state_nxt.number_closed = 1'b0;
               end else if (b == tkd_pkg::CH_SS3) begin
                  state_nxt.phase = tkd_pkg::PH_SS3;
               end else begin
                  dec_out.emit              = 1'b1;
                  dec_out.result.event_kind = tkd_pkg::KIND_KEY;
                  dec_out.result.key_code   = tkd_pkg::K_ESCAPE;
               end
            end

            tkd_pkg::PH_CSI: begin
               state_nxt.wait_count = '0;
               if (b >= tkd_pkg::CH_ZERO && b <= tkd_pkg::CH_NINE) begin
                  // digits after the first ';' are swallowed
                  if (!state_cur.number_closed) begin
                     state_nxt.first_number = (num_acc > {4'd0, tkd_pkg::NUM_MAX}) ?
                                              tkd_pkg::NUM_SAT : num_acc[6:0];
                     state_nxt.digit_seen   = 1'b1;
                  end
               end else if (b == tkd_pkg::CH_SEMI) begin
                  state_nxt.number_closed = 1'b1;
               end else begin
                  dec_out.emit              = 1'b1;
                  dec_out.result.event_kind = tkd_pkg::KIND_KEY;
                  if (b == tkd_pkg::CH_TILDE) begin
                     key = state_cur.digit_seen ? tkd_pkg::tilde_key(state_cur.first_number)
                                                : tkd_pkg::NO_KEY;
                  end else begin
                     unique case (b)
                        tkd_pkg::CH_A: key = tkd_pkg::K_UP;
                        tkd_pkg::CH_B: key = tkd_pkg::K_DOWN;
                        tkd_pkg::CH_C: key = tkd_pkg::K_RIGHT;
                        tkd_pkg::CH_D: key = tkd_pkg::K_LEFT;
                        tkd_pkg::CH_H: key = tkd_pkg::K_HOME;
                        tkd_pkg::CH_F: key = tkd_pkg::K_END;
                        default:       key = tkd_pkg::NO_KEY;
                     endcase
                  end
                  dec_out.result.key_code = (key == tkd_pkg::NO_KEY) ? tkd_pkg::K_ESCAPE : key;
               end
            end

            tkd_pkg::PH_SS3: begin
               dec_out.emit = 1'b1;
               unique case (b)
                  tkd_pkg::CH_P: key = tkd_pkg::K_F1;
                  tkd_pkg::CH_Q: key = tkd_pkg::K_F2;
                  tkd_pkg::CH_R: key = tkd_pkg::K_F3;
                  tkd_pkg::CH_S: key = tkd_pkg::K_F4;
                  tkd_pkg::CH_H: key = tkd_pkg::K_HOME;
                  tkd_pkg::CH_F: key = tkd_pkg::K_END;
                  default:       key = tkd_pkg::NO_KEY;
               endcase
               if (key == tkd_pkg::NO_KEY) begin
                  dec_out.result.event_kind = tkd_pkg::KIND_SS3;
                  dec_out.result.byte_out   = tkd_pkg::CH_SS3;
               end else begin
                  dec_out.result.event_kind = tkd_pkg::KIND_KEY;
                  dec_out.result.key_code   = key;
               end
            end

            default: begin
               state_nxt = state_cur;
            end
         endcase
      end

      // any event ends the sequence
      if (dec_out.emit) begin
         state_nxt.phase      = tkd_pkg::PH_IDLE;
         state_nxt.wait_count = '0;
      end
   end

endmodule

@@ design/terminal_key_escape_decoder_unit.sv @@
// Terminal key escape decoder, top level: request register, decode, response register,
// configuration registers. Depends on tkd_pkg, tkd_req_if, tkd_rsp_if and tkd_decode.
//
// Takes one request per clock while no response is stalled: a received byte (action 0)
// or a one-millisecond tick (action 1), and gives zero or one key event per request,
// in order. A request is captured in an input register and decoded against the
// sequence state once the response register is free; the event, if any, lands in the
// response register, from which it is offered. The decode stage advances whenever the
// response register is empty or being drained, so with rsp ready held high a new
// request is taken every cycle; a stalled response holds back one request in the input
// register and then ready drops. Write esc_wait_ticks (index 0) and seq_wait_ticks
// (index 1) only while no request is in flight.
module terminal_key_escape_decoder_unit (
   input  logic                             clock,
   input  logic                             reset,
   tkd_req_if.sink                          req_ch,
   tkd_rsp_if.source                        rsp_ch,
   input  logic                             csr_write_enable,
   input  logic [tkd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [tkd_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   logic                  in_valid_ff;
   logic                  in_valid_in;
   tkd_pkg::req_type      in_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   tkd_pkg::rsp_type      rsp_ff;
   tkd_pkg::state_type    state_ff;
   tkd_pkg::state_type    state_in;
   tkd_pkg::dec_out_type  dec_out;
   logic [15:0]           esc_wait_ff;
   logic [15:0]           seq_wait_ff;
   logic                  out_free;
   logic                  fire;
   logic                  req_take;

   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign fire         = in_valid_ff && out_free;
   assign req_ch.ready = !in_valid_ff || fire;
   assign req_take     = req_ch.valid && req_ch.ready;

   assign in_valid_in  = req_take ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = fire ? dec_out.emit : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);

   tkd_decode u_decode (
      .state_cur (state_ff),
      .req_cur   (in_ff),
      .esc_wait  (esc_wait_ff),
      .seq_wait  (seq_wait_ff),
      .state_nxt (state_in),
      .dec_out   (dec_out)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
         esc_wait_ff  <= tkd_pkg::ESC_WAIT_RESET;
         seq_wait_ff  <= tkd_pkg::SEQ_WAIT_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            state_ff <= state_in;
         end
         if (csr_write_enable) begin
            unique case (csr_index)
               tkd_pkg::CSR_ESC_WAIT: esc_wait_ff <= csr_write_data;
               tkd_pkg::CSR_SEQ_WAIT: seq_wait_ff <= csr_write_data;
               default:               esc_wait_ff <= esc_wait_ff;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ff.action  <= req_ch.action;
         in_ff.byte_in <= req_ch.byte_in;
      end
      if (fire && dec_out.emit) begin
         rsp_ff <= dec_out.result;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.event_kind = rsp_ff.event_kind;
   assign rsp_ch.key_code   = rsp_ff.key_code;
   assign rsp_ch.byte_out   = rsp_ff.byte_out;

   // a request waiting on a stalled response stays put
   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !fire |=> in_valid_ff && $stable(in_ff))
      else $error("input register lost a request while stalled");

   // every event returns the decoder to idle
   a_emit_idle: assert property (@(posedge clock) disable iff (reset)
      fire && dec_out.emit |=> state_ff.phase == tkd_pkg::PH_IDLE)
      else $error("decoder not idle after an event");

   // the tick counter only runs inside a sequence
   a_idle_count: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == tkd_pkg::PH_IDLE |-> state_ff.wait_count == '0)
      else $error("wait count nonzero while idle");

   a_num_sat: assert property (@(posedge clock) disable iff (reset)
      state_ff.first_number <= tkd_pkg::NUM_SAT)
      else $error("first number above saturation value");

   a_ss3_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.event_kind == tkd_pkg::KIND_SS3
      |-> rsp_ff.byte_out == tkd_pkg::CH_SS3 && rsp_ff.key_code == '0)
      else $error("malformed unknown-SS3 event");

endmodule

@@ sim/tb_terminal_key_escape_decoder_unit.sv @@
`timescale 1ns / 1ps
// Testbench for terminal_key_escape_decoder_unit: random byte/tick requests with a cycle-free
// predictor and an in-order event scoreboard. Depends on tkd_pkg, tkd_req_if, tkd_rsp_if.
module tb_terminal_key_escape_decoder_unit;
   import tkd_pkg::*;

   localparam int QUIET_LIMIT  = 2000;
   localparam int PHASE_ITEMS  = 265;
   localparam int MAX_PRINTED  = 100;
   localparam int SETTLE_TICKS = 4;

   class key_event_scoreboard;
      rsp_type     expected_events[$];
      int          errors;
      logic [1:0]  phase;
      logic [15:0] wait_count;
      logic [6:0]  first_num;
      logic        digit_seen;
      logic        num_closed;
      logic [15:0] esc_wait;
      logic [15:0] seq_wait;

      function new();
         errors     = 0;
         phase      = PH_IDLE;
         wait_count = '0;
         first_num  = '0;
         digit_seen = 1'b0;
         num_closed = 1'b0;
         esc_wait   = ESC_WAIT_RESET;
         seq_wait   = SEQ_WAIT_RESET;
      endfunction

      function void set_wait(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         if (idx == CSR_ESC_WAIT)
            esc_wait = value;
         else if (idx == CSR_SEQ_WAIT)
            seq_wait = value;
      endfunction

      function int pending();
         return expected_events.size();
      endfunction

      function rsp_type make_event(logic [1:0] kind, logic [5:0] key, logic [7:0] ch);
         rsp_type ev;
         ev.event_kind = kind;
         ev.key_code   = key;
         ev.byte_out   = ch;
         return ev;
      endfunction

      function logic [5:0] control_key(logic [4:0] c);
         case (c)
            5'd1:    return K_CTRL_A;
            5'd3:    return K_CTRL_C;
            5'd4:    return K_CTRL_D;
            5'd5:    return K_CTRL_E;
            5'd6:    return K_CTRL_F;
            5'd9:    return K_TAB;
            5'd10,
            5'd13:   return K_ENTER;
            5'd11:   return K_CTRL_K;
            5'd12:   return K_CTRL_L;
            5'd14:   return K_CTRL_N;
            5'd16:   return K_CTRL_P;
            5'd21:   return K_CTRL_U;
            5'd23:   return K_CTRL_W;
            5'd24:   return K_CTRL_X;
            5'd26:   return K_CTRL_Z;
            5'd27:   return K_ESCAPE;
            default: return NO_KEY;
         endcase
      endfunction

      function logic [5:0] number_key(logic [6:0] n);
         case (n)
            7'd1:    return K_HOME;
            7'd2:    return K_INSERT;
            7'd3:    return K_DELETE;
            7'd4:    return K_END;
            7'd5:    return K_PAGE_UP;
            7'd6:    return K_PAGE_DOWN;
            7'd15:   return K_F5;
            7'd17:   return K_F6;
            7'd18:   return K_F7;
            7'd19:   return K_F8;
            7'd20:   return K_F9;
            7'd21:   return K_F10;
            7'd23:   return K_F11;
            7'd24:   return K_F12;
            default: return NO_KEY;
         endcase
      endfunction

      // Advance the decoder state by one request; queue the event it produces, if any.
      function void note_request(logic act, logic [7:0] b);
         rsp_type     ev;
         logic        fire;
         logic [15:0] lim;
         logic [5:0]  k;
         int          v;
         fire = 1'b0;
         ev   = '0;
         if (act == ACT_TICK) begin
            if (phase != PH_IDLE) begin
               lim        = (phase == PH_ESC) ? esc_wait : seq_wait;
               wait_count = wait_count + 16'd1;
               if (wait_count >= lim) begin
                  fire = 1'b1;
                  ev   = (phase == PH_SS3) ? make_event(KIND_SS3, '0, CH_SS3)
                                           : make_event(KIND_KEY, K_ESCAPE, '0);
               end
            end
         end else begin
            case (phase)
               PH_IDLE: begin
                  if (b == CH_ESC) begin
                     phase      = PH_ESC;
                     wait_count = '0;
                  end else if (b < CH_SPACE) begin
                     k    = control_key(b[4:0]);
                     fire = 1'b1;
                     ev   = (k == NO_KEY) ? make_event(KIND_CTRL, '0, b)
                                          : make_event(KIND_KEY, k, '0);
                  end else begin
                     fire = 1'b1;
                     ev   = make_event(KIND_CHAR, '0, b);
                  end
               end
               PH_ESC: begin
                  wait_count = '0;
                  if (b == CH_LBRACKET) begin
                     phase      = PH_CSI;
                     first_num  = '0;
                     digit_seen = 1'b0;
                     num_closed = 1'b0;
                  end else if (b == CH_SS3) begin
                     phase = PH_SS3;
                  end else begin
                     fire = 1'b1;
                     ev   = make_event(KIND_KEY, K_ESCAPE, '0);
                  end
               end
               PH_CSI: begin
                  wait_count = '0;
                  if (b >= CH_ZERO && b <= CH_NINE) begin
                     // only the first number counts; it saturates above 99
                     if (!num_closed) begin
                        v          = int'(first_num) * 10 + (int'(b) - int'(CH_ZERO));
                        first_num  = (v > int'(NUM_MAX)) ? NUM_SAT : v[6:0];
                        digit_seen = 1'b1;
                     end
                  end else if (b == CH_SEMI) begin
                     num_closed = 1'b1;
                  end else begin
                     fire = 1'b1;
                     if (b == CH_TILDE)
                        k = digit_seen ? number_key(first_num) : NO_KEY;
                     else if (b == CH_A)
                        k = K_UP;
                     else if (b == CH_B)
                        k = K_DOWN;
                     else if (b == CH_C)
                        k = K_RIGHT;
                     else if (b == CH_D)
                        k = K_LEFT;
                     else if (b == CH_H)
                        k = K_HOME;
                     else if (b == CH_F)
                        k = K_END;
                     else
                        k = NO_KEY;
                     ev = make_event(KIND_KEY, (k == NO_KEY) ? K_ESCAPE : k, '0);
                  end
               end
               default: begin
                  fire = 1'b1;
                  if (b == CH_P)
                     ev = make_event(KIND_KEY, K_F1, '0);
                  else if (b == CH_Q)
                     ev = make_event(KIND_KEY, K_F2, '0);
                  else if (b == CH_R)
                     ev = make_event(KIND_KEY, K_F3, '0);
                  else if (b == CH_S)
                     ev = make_event(KIND_KEY, K_F4, '0);
                  else if (b == CH_H)
                     ev = make_event(KIND_KEY, K_HOME, '0);
                  else if (b == CH_F)
                     ev = make_event(KIND_KEY, K_END, '0);
                  else
                     ev = make_event(KIND_SS3, '0, CH_SS3);
               end
            endcase
         end
         if (fire) begin
            expected_events.push_back(ev);
            phase      = PH_IDLE;
            wait_count = '0;
         end
      endfunction

      task report(string msg);
         errors++;
         if (errors <= MAX_PRINTED)
            $display("tb: mismatch at %0t: %s", $realtime, msg);
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         if (expected_events.size() == 0) begin
            report($sformatf("unexpected event kind %0d key %0d byte %0d",
                             got.event_kind, got.key_code, got.byte_out));
         end else begin
            want = expected_events.pop_front();
            if (got.event_kind !== want.event_kind)
               report($sformatf("event_kind %0d, want %0d", got.event_kind, want.event_kind));
            if (got.key_code !== want.key_code)
               report($sformatf("key_code %0d, want %0d", got.key_code, want.key_code));
            if (got.byte_out !== want.byte_out)
               report($sformatf("byte_out %0d, want %0d", got.byte_out, want.byte_out));
         end
      endtask
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   tkd_req_if req_ch();
   tkd_rsp_if rsp_ch();

   terminal_key_escape_decoder_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   key_event_scoreboard sb = new();

   int          items_sent   = 0;
   int          quiet_cycles = 0;
   logic        calm         = 1'b0;
   logic [15:0] esc_cfg      = ESC_WAIT_RESET;
   logic [15:0] seq_cfg      = SEQ_WAIT_RESET;
   int          tilde_numbers [14] = '{1, 2, 3, 4, 5, 6, 15, 17, 18, 19, 20, 21, 23, 24};
   logic [7:0]  csi_finals [6] = '{CH_A, CH_B, CH_C, CH_D, CH_H, CH_F};
   logic [7:0]  ss3_finals [6] = '{CH_P, CH_Q, CH_R, CH_S, CH_H, CH_F};

   always #4 clock = ~clock;

   initial begin
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = CSR_ESC_WAIT;
      csr_write_data   = '0;
      req_ch.valid     = 1'b0;
      req_ch.action    = ACT_BYTE;
      req_ch.byte_in   = '0;
      rsp_ch.ready     = 1'b0;
   end

   // response side: random stall before each event, none while calm
   initial begin
      int stall;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = calm ? 0 : $urandom_range(0, 17);
         repeat (stall) begin
            @(negedge clock);
            rsp_ch.ready <= 1'b0;
         end
         @(negedge clock);
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_result('{event_kind: rsp_ch.event_kind, key_code: rsp_ch.key_code,
                           byte_out: rsp_ch.byte_out});
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic send_request(input logic act, input logic [7:0] b);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 17);
      repeat (gap) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
      @(negedge clock);
      req_ch.valid   <= 1'b1;
      req_ch.action  <= act;
      req_ch.byte_in <= b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note_request(act, b);
      items_sent++;
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_request(ACT_BYTE, b);
   endtask

   // the byte lane of a tick is don't-care, so it carries noise
   task automatic send_ticks(input int n);
      repeat (n) send_request(ACT_TICK, 8'($urandom_range(0, 255)));
   endtask

   task automatic maybe_tick();
      if ($urandom_range(0, 7) == 0)
         send_ticks(1);
   endtask

   task automatic send_number(input int num);
      string s;
      if ($urandom_range(0, 5) == 0)
         send_byte(CH_ZERO);
      s = $sformatf("%0d", num);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i]);
   endtask

   // lets the pipeline empty before a register write
   task automatic wait_for_idle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() > 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [15:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      sb.set_wait(idx, value);
      if (idx == CSR_ESC_WAIT)
         esc_cfg = value;
      else
         seq_cfg = value;
   endtask

   function automatic int timeout_ticks(input logic [15:0] lim);
      return (lim <= 16'd40) ? int'(lim) + $urandom_range(0, 1) : $urandom_range(1, 6);
   endfunction

   task automatic run_random_sequence();
      int sel;
      int n;
      sel  = $urandom_range(0, 99);
      calm = ($urandom_range(0, 4) == 0);
      if (sel < 15) begin
         send_byte(8'($urandom_range(0, 255)));
      end else if (sel < 20) begin
         send_ticks($urandom_range(1, 3));
      end else if (sel < 45) begin
         send_byte(CH_ESC);
         send_byte(CH_LBRACKET);
         maybe_tick();
         if ($urandom_range(0, 9) == 0) begin
            send_byte(CH_SEMI);             // leading ';', no first number
         end else if ($urandom_range(0, 2) != 0) begin
            case ($urandom_range(0, 3))
               0, 1:    send_number(tilde_numbers[$urandom_range(0, 13)]);
               2:       send_number($urandom_range(0, 99));
               default: send_number($urandom_range(100, 99999));
            endcase
         end
         if ($urandom_range(0, 3) == 0) begin
            send_byte(CH_SEMI);
            send_number($urandom_range(0, 99));
         end
         maybe_tick();
         if ($urandom_range(0, 3) == 0)
            send_byte(csi_finals[$urandom_range(0, 5)]);
         else
            send_byte(CH_TILDE);
      end else if (sel < 60) begin
         send_byte(CH_ESC);
         send_byte(CH_SS3);
         maybe_tick();
         if ($urandom_range(0, 4) != 0)
            send_byte(ss3_finals[$urandom_range(0, 5)]);
         else
            send_byte(8'($urandom_range(0, 255)));
      end else if (sel < 70) begin
         send_byte(CH_ESC);
         send_byte(8'($urandom_range(0, 255)));
      end else if (sel < 78) begin
         send_byte(CH_ESC);
         send_ticks(timeout_ticks(esc_cfg));
      end else if (sel < 88) begin
         send_byte(CH_ESC);
         if ($urandom_range(0, 1) == 0) begin
            send_byte(CH_LBRACKET);
            if ($urandom_range(0, 1) == 0)
               send_number($urandom_range(0, 30));
         end else begin
            send_byte(CH_SS3);
         end
         send_ticks(timeout_ticks(seq_cfg));
      end else begin
         // broken CSI: arbitrary bytes after the introducer
         send_byte(CH_ESC);
         send_byte(CH_LBRACKET);
         n = $urandom_range(1, 4);
         repeat (n) send_byte(8'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      logic [15:0] esc_settings [6];
      logic [15:0] seq_settings [6];
      int          phase_end;
      esc_settings = '{16'd1, 16'd0, 16'hFFFF, 16'd3, ESC_WAIT_RESET, 16'd0};
      seq_settings = '{16'd1, 16'hFFFF, 16'd0, 16'd2, SEQ_WAIT_RESET, 16'd0};
      esc_settings[5] = 16'($urandom_range(1, 40));
      seq_settings[5] = 16'($urandom_range(1, 40));

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // plain bytes at the edges of the control and printable ranges, then an idle tick and fixed escape sequences
      send_byte(8'd0);
      send_byte(8'd1);
      send_byte(8'd31);
      send_byte(CH_SPACE);
      send_byte(8'd127);
      send_byte(8'd255);
      send_ticks(1);                        // idle tick: nothing comes out
      send_byte(CH_ESC);
      send_byte(CH_LBRACKET);
      send_byte(CH_A);
      send_byte(CH_ESC);
      send_byte(CH_SS3);
      send_byte(CH_P);
      send_byte(CH_ESC);
      send_byte(CH_LBRACKET);
      send_byte(CH_SEMI);
      send_byte(CH_TILDE);
      send_byte(CH_ESC);
      send_byte(8'h78);                     // neither '[' nor 'O'
      send_byte(CH_ESC);
      send_byte(CH_SS3);
      send_byte(8'h7A);
      send_byte(CH_ESC);
      send_byte(CH_LBRACKET);
      send_number(24);
      send_byte(CH_TILDE);

      for (int p = 0; p < 6; p++) begin
         wait_for_idle();
         write_csr(CSR_ESC_WAIT, esc_settings[p]);
         write_csr(CSR_SEQ_WAIT, seq_settings[p]);
         phase_end = items_sent + PHASE_ITEMS;
         while (items_sent < phase_end)
            run_random_sequence();
      end

      calm = 1'b0;
      wait_for_idle();
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
